// ===== design/midi_note_pair_matcher_top_macros.svh =====
// Assertion macros shared by the note pair matcher modules.
// Every macro samples on clk_i; the modules that use them provide clk_i and rst_ni.
`ifndef MIDI_NOTE_PAIR_MATCHER_TOP_MACROS_SVH
`define MIDI_NOTE_PAIR_MATCHER_TOP_MACROS_SVH

// checked only outside reset
`define MNPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define MNPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/mnpm_pkg.sv =====
// Types, codes and helpers for the MIDI note pair matcher.
// No dependencies.
package mnpm_pkg;

  localparam int KeyBits = 11;
  localparam int KeyCount = 2048;
  localparam int VelBits = 7;
  localparam int SvelBits = 16;
  localparam int CfgBits = 20;
  localparam int MaxSndBits = 9;
  localparam int MaxFinBits = 20;

  typedef enum logic [1:0] {
    OP_ON  = 2'd0,
    OP_OFF = 2'd1,
    OP_END = 2'd2,
    OP_BAD = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_QUEUED    = 4'd0,
    ST_DONE      = 4'd1,
    ST_SND_LIMIT = 4'd2,
    ST_UNMATCHED = 4'd3,
    ST_NONPOS    = 4'd4,
    ST_NOTE_LIM  = 4'd5,
    ST_END_OK    = 4'd6,
    ST_END_EMPTY = 4'd7,
    ST_END_SOUND = 4'd8,
    ST_IGNORED   = 4'd9
  } status_e;

  typedef enum logic [0:0] {
    CFG_MAX_SND = 1'b0,
    CFG_MAX_FIN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic latch;
    logic commit;
    logic slot_phase;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic failed;
    logic head_valid;
    logic out_free;
    logic clear_done;
  } sts_t;

  // (v*65535+63)/127 = 516*v + (3*v+63)/127, the quotient being 0..3
  function automatic logic [SvelBits-1:0] scale_vel(logic [VelBits-1:0] v);
    logic [8:0] t;
    logic [1:0] q;
    t = 9'(3 * v) + 9'd63;
    if (t >= 9'd381) q = 2'd3;
    else if (t >= 9'd254) q = 2'd2;
    else if (t >= 9'd127) q = 2'd1;
    else q = 2'd0;
    return 16'(v * 516) + 16'(q);
  endfunction

endpackage

// ===== design/mnpm_if.sv =====
// Request and response channel interfaces of the note pair matcher.
// Depends on mnpm_pkg for field widths.
interface mnpm_req_if
  import mnpm_pkg::*;
#(
  parameter int TICK_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [TICK_BITS-1:0] tick;
  logic [3:0]           channel;
  logic [6:0]           pitch;
  logic [VelBits-1:0]   velocity;

  modport source (output valid, operation, tick, channel, pitch, velocity, input ready);
  modport sink (input valid, operation, tick, channel, pitch, velocity, output ready);
endinterface

interface mnpm_rsp_if
  import mnpm_pkg::*;
#(
  parameter int TICK_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [3:0]           status;
  logic [TICK_BITS-1:0] start_tick;
  logic [TICK_BITS-1:0] length_ticks;
  logic [SvelBits-1:0]  scaled_velocity;
  logic [6:0]           note_pitch;
  logic [3:0]           note_channel;

  modport source (output valid, status, start_tick, length_ticks, scaled_velocity,
                  note_pitch, note_channel, input ready);
  modport sink (input valid, status, start_tick, length_ticks, scaled_velocity,
                note_pitch, note_channel, output ready);
endinterface

// ===== design/midi_note_pair_matcher_top.sv =====
// Note-on/note-off pairing; a matched note-off adds a slot-read state before its commit.
// One item at a time; the key-chain and slot memory read then write-back sets the rate.
// The output register lets the next item be taken while a result waits.
// After reset and after every end of track a sweep over max(2048, NOTE_SLOTS) entries
// clears the chain heads and refills the free-slot list; no item is taken meanwhile.
// Top level: joins the sequencer and the datapath; depends on mnpm_pkg and mnpm_if.
module midi_note_pair_matcher_top
  import mnpm_pkg::*;
#(
  parameter int NOTE_SLOTS = 256,
  parameter int TICK_BITS  = 48
)(
  input  logic               clk_i,
  input  logic               rst_ni,
  mnpm_req_if.sink           req_i,
  mnpm_rsp_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CfgBits-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  mnpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mnpm_dpath #(
    .NOTE_SLOTS (NOTE_SLOTS),
    .TICK_BITS  (TICK_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (req_i.operation),
    .in_tick_i    (req_i.tick),
    .in_chan_i    (req_i.channel),
    .in_pitch_i   (req_i.pitch),
    .in_vel_i     (req_i.velocity),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_start_o  (rsp_o.start_tick),
    .out_len_o    (rsp_o.length_ticks),
    .out_svel_o   (rsp_o.scaled_velocity),
    .out_pitch_o  (rsp_o.note_pitch),
    .out_chan_o   (rsp_o.note_channel)
  );

endmodule

// ===== design/mnpm_ctrl.sv =====
// Sequencer of the note pair matcher: clear sweep, lookup, slot read, commit.
// Depends on mnpm_pkg and the assertion macro header.
`include "midi_note_pair_matcher_top_macros.svh"

module mnpm_ctrl
  import mnpm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_SLOT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        // a matched note-off needs its slot read first
        if (sts_i.op == OP_OFF && !sts_i.failed && sts_i.head_valid) begin
          state_d = S_SLOT;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = (sts_i.op == OP_END) ? S_CLEAR : S_IDLE;
        end
      end
      S_SLOT: begin
        cmd_o.slot_phase = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  `MNPM_ASSERT(a_commit_out_free, cmd_o.commit |-> sts_i.out_free, "commit with busy output")
  `MNPM_ASSERT(a_end_clears, (cmd_o.commit && !cmd_o.slot_phase && sts_i.op == OP_END) |=> state_q == S_CLEAR, "end of track did not start clear")
  `MNPM_ASSERT(a_clear_exit, (state_q == S_CLEAR && sts_i.clear_done) |=> in_ready_o, "clear sweep did not finish")
  `MNPM_ASSERT_ALWAYS(a_ready_no_work, in_ready_o |-> (!cmd_o.commit && !cmd_o.clear_step), "ready while busy")

endmodule

// ===== design/mnpm_dpath.sv =====
// Datapath of the note pair matcher: key chains, slot pool, counters, output register.
// Depends on mnpm_pkg.
module mnpm_dpath
  import mnpm_pkg::*;
#(
  parameter int NOTE_SLOTS = 256,
  parameter int TICK_BITS  = 48
)(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [1:0]           in_op_i,
  input  logic [TICK_BITS-1:0] in_tick_i,
  input  logic [3:0]           in_chan_i,
  input  logic [6:0]           in_pitch_i,
  input  logic [VelBits-1:0]   in_vel_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CfgBits-1:0]   cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           out_status_o,
  output logic [TICK_BITS-1:0] out_start_o,
  output logic [TICK_BITS-1:0] out_len_o,
  output logic [SvelBits-1:0]  out_svel_o,
  output logic [6:0]           out_pitch_o,
  output logic [3:0]           out_chan_o
);

  localparam int SlotW = $clog2(NOTE_SLOTS);
  localparam int CntW = SlotW + 1;
  localparam int CmpW = (CntW > MaxSndBits) ? CntW : MaxSndBits;
  localparam int ClrCount = (KeyCount > NOTE_SLOTS) ? KeyCount : NOTE_SLOTS;
  localparam int ClrW = $clog2(ClrCount);
  // one extra bit so that the sweep bounds are representable
  localparam int ClrCmpW = ClrW + 1;
  localparam int DataW = TICK_BITS + VelBits;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
  } head_t;

  // latched item
  op_e                  op_q;
  logic [TICK_BITS-1:0] tick_q;
  logic [3:0]           chan_q;
  logic [6:0]           pitch_q;
  logic [VelBits-1:0]   vel_q;

  logic [MaxSndBits-1:0] max_snd_q;
  logic [MaxFinBits-1:0] max_fin_q;

  logic [CntW-1:0]       cnt_q;
  logic [MaxFinBits-1:0] fin_q;
  logic [TICK_BITS-1:0]  early_q, late_q;
  logic                  failed_q;
  logic [ClrW-1:0]       clr_q;

  head_t            head_mem [KeyCount];
  logic [SlotW-1:0] tail_mem [KeyCount];
  logic [SlotW-1:0] free_mem [NOTE_SLOTS];
  logic [DataW-1:0] data_mem [NOTE_SLOTS];
  logic [SlotW-1:0] next_mem [NOTE_SLOTS];

  head_t            head_rd_q;
  logic [SlotW-1:0] tail_rd_q, free_rd_q, next_rd_q;
  logic [DataW-1:0] data_rd_q;

  logic [KeyBits-1:0]   key_q, rd_key;
  logic [SlotW-1:0]     pop_pos, push_pos;
  logic                 limit, on_commit, off_commit, end_commit, clear_done;
  logic                 clr_head, clr_free, out_free;
  logic [TICK_BITS-1:0] start;
  logic [VelBits-1:0]   start_vel;
  logic                 nonpos, fin_full;

  logic                 res_fail;
  status_e              res_status;
  logic [TICK_BITS-1:0] res_start, res_len;
  logic [SvelBits-1:0]  res_svel;
  logic [6:0]           res_pitch;
  logic [3:0]           res_chan;

  logic                 out_valid_q;
  logic [3:0]           out_status_q;
  logic [TICK_BITS-1:0] out_start_q, out_len_q;
  logic [SvelBits-1:0]  out_svel_q;
  logic [6:0]           out_pitch_q;
  logic [3:0]           out_chan_q;

  assign key_q = {chan_q, pitch_q};
  assign rd_key = cmd_i.latch ? {in_chan_i, in_pitch_i} : key_q;
  assign pop_pos = SlotW'(CntW'(NOTE_SLOTS - 1) - cnt_q);
  assign push_pos = SlotW'(CntW'(NOTE_SLOTS) - cnt_q);
  assign limit = (CmpW'(cnt_q) >= CmpW'(max_snd_q)) || (cnt_q >= CntW'(NOTE_SLOTS));
  assign clear_done = (clr_q == ClrW'(ClrCount - 1));
  assign clr_head = cmd_i.clear_step && (ClrCmpW'(clr_q) < ClrCmpW'(KeyCount));
  assign clr_free = cmd_i.clear_step && (ClrCmpW'(clr_q) < ClrCmpW'(NOTE_SLOTS));
  assign out_free = !out_valid_q || out_ready_i;

  assign on_commit = cmd_i.commit && !cmd_i.slot_phase && op_q == OP_ON && !failed_q && !limit;
  assign off_commit = cmd_i.commit && cmd_i.slot_phase;
  assign end_commit = cmd_i.commit && !cmd_i.slot_phase && op_q == OP_END;

  assign start = data_rd_q[DataW-1:VelBits];
  assign start_vel = data_rd_q[VelBits-1:0];
  assign nonpos = (tick_q <= start);
  assign fin_full = (fin_q >= max_fin_q);

  assign sts_o.op = op_q;
  assign sts_o.failed = failed_q;
  assign sts_o.head_valid = head_rd_q.valid;
  assign sts_o.out_free = out_free;
  assign sts_o.clear_done = clear_done;

  // result of the item in its commit cycle
  always_comb begin
    res_status = ST_IGNORED;
    res_fail = 1'b0;
    res_start = '0;
    res_len = '0;
    res_svel = '0;
    res_pitch = '0;
    res_chan = '0;
    if (cmd_i.slot_phase) begin
      if (nonpos) begin
        res_status = ST_NONPOS;
        res_fail = 1'b1;
      end else if (fin_full) begin
        res_status = ST_NOTE_LIM;
        res_fail = 1'b1;
      end else begin
        res_status = ST_DONE;
        res_start = start;
        res_len = tick_q - start;
        res_svel = scale_vel(start_vel);
        res_pitch = pitch_q;
        res_chan = chan_q;
      end
    end else if (op_q == OP_END) begin
      if (failed_q) begin
        res_status = ST_IGNORED;
      end else if (cnt_q != '0) begin
        res_status = ST_END_SOUND;
        res_len = TICK_BITS'(cnt_q);
      end else if (fin_q == '0) begin
        res_status = ST_END_EMPTY;
      end else begin
        res_status = ST_END_OK;
        res_start = early_q;
        res_len = late_q - early_q;
      end
    end else if (op_q == OP_BAD || failed_q) begin
      res_status = ST_IGNORED;
    end else if (op_q == OP_ON) begin
      res_status = limit ? ST_SND_LIMIT : ST_QUEUED;
      res_fail = limit;
    end else begin
      // note-off with an empty chain
      res_status = ST_UNMATCHED;
      res_fail = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= op_e'(in_op_i);
      tick_q <= in_tick_i;
      chan_q <= in_chan_i;
      pitch_q <= in_pitch_i;
      vel_q <= in_vel_i;
    end
  end

  // memories, registered reads
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[rd_key];
    if (clr_head) head_mem[clr_q[KeyBits-1:0]] <= '0;
    else if (on_commit && !head_rd_q.valid) head_mem[key_q] <= '{valid: 1'b1, slot: free_rd_q};
    else if (off_commit) begin
      if (tail_rd_q == head_rd_q.slot) head_mem[key_q] <= '0;
      else head_mem[key_q] <= '{valid: 1'b1, slot: next_rd_q};
    end
  end

  always_ff @(posedge clk_i) begin
    tail_rd_q <= tail_mem[rd_key];
    if (on_commit) tail_mem[key_q] <= free_rd_q;
  end

  always_ff @(posedge clk_i) begin
    free_rd_q <= free_mem[pop_pos];
    if (clr_free) free_mem[clr_q[SlotW-1:0]] <= clr_q[SlotW-1:0];
    else if (off_commit) free_mem[push_pos] <= head_rd_q.slot;
  end

  always_ff @(posedge clk_i) begin
    data_rd_q <= data_mem[head_rd_q.slot];
    if (on_commit) data_mem[free_rd_q] <= {tick_q, vel_q};
  end

  always_ff @(posedge clk_i) begin
    next_rd_q <= next_mem[head_rd_q.slot];
    if (on_commit && head_rd_q.valid) next_mem[tail_rd_q] <= free_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_snd_q <= MaxSndBits'(256);
      max_fin_q <= {MaxFinBits{1'b1}};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_SND: max_snd_q <= cfg_data_i[MaxSndBits-1:0];
        CFG_MAX_FIN: max_fin_q <= cfg_data_i[MaxFinBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fin_q <= '0;
      early_q <= '1;
      late_q <= '0;
      failed_q <= 1'b0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clear_done ? '0 : clr_q + 1'b1;
      if (end_commit) begin
        cnt_q <= '0;
        fin_q <= '0;
        early_q <= '1;
        late_q <= '0;
        failed_q <= 1'b0;
      end else if (cmd_i.commit) begin
        if (res_fail) failed_q <= 1'b1;
        if (on_commit) cnt_q <= cnt_q + 1'b1;
        if (off_commit) begin
          cnt_q <= cnt_q - 1'b1;
          if (res_status == ST_DONE) begin
            fin_q <= fin_q + 1'b1;
            if (start < early_q) early_q <= start;
            if (tick_q > late_q) late_q <= tick_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.commit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_start_q <= res_start;
      out_len_q <= res_len;
      out_svel_q <= res_svel;
      out_pitch_q <= res_pitch;
      out_chan_q <= res_chan;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_start_o = out_start_q;
  assign out_len_o = out_len_q;
  assign out_svel_o = out_svel_q;
  assign out_pitch_o = out_pitch_q;
  assign out_chan_o = out_chan_q;

endmodule

// ===== tb/tb_midi_note_pair_matcher_top.sv =====
// Self-checking bench for midi_note_pair_matcher_top: directed table, limit checks, then random tracks.
// Predicts results with an in-bench note pairing model or takes them from the table; depends on mnpm_pkg and mnpm_if.
`timescale 1ns / 100ps

module tb_midi_note_pair_matcher_top;
  import mnpm_pkg::*;

  localparam int SLOTS = 256;
  localparam int TB = 48;
  localparam logic [TB-1:0] TMAX = '1;
  localparam int WATCHDOG = 10000;

  typedef struct packed {
    status_e       status;
    logic [TB-1:0] start;
    logic [TB-1:0] len;
    logic [15:0]   svel;
    logic [6:0]    pitch;
    logic [3:0]    chan;
  } note_res_t;

  typedef struct {
    op_e           op;
    logic [TB-1:0] tick;
    logic [3:0]    chan;
    logic [6:0]    pitch;
    logic [6:0]    vel;
    bit            typed;
    note_res_t     res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CfgBits-1:0] cfg_data_i;

  mnpm_req_if #(.TICK_BITS(TB)) req_if ();
  mnpm_rsp_if #(.TICK_BITS(TB)) rsp_if ();

  midi_note_pair_matcher_top #(.NOTE_SLOTS(SLOTS), .TICK_BITS(TB)) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  bit            hv[KeyCount];
  int            head[KeyCount];
  int            tail[KeyCount];
  logic [TB-1:0] s_tick[SLOTS];
  logic [6:0]    s_vel[SLOTS];
  int            s_next[SLOTS];
  int            free_list[SLOTS];
  int            sounding, finished;
  logic [TB-1:0] earliest, latest;
  bit            failed;
  int            max_snd = 256;
  int            max_fin = 1048575;

  note_res_t due_q[$];
  stim_row_t table_q[$];
  int        open_keys[$];
  int        errors, checked, sent, stall_cycles;
  int        status_seen[16];
  int        tx_pct, rx_pct, hold_left;

  function automatic void clear_track();
    for (int i = 0; i < KeyCount; i++) hv[i] = 0;
    for (int i = 0; i < SLOTS; i++) free_list[i] = i;
    sounding = 0;
    finished = 0;
    earliest = TMAX;
    latest = '0;
    failed = 0;
  endfunction

  function automatic note_res_t match_note(op_e op, logic [TB-1:0] tick, logic [3:0] ch,
                                           logic [6:0] p, logic [6:0] v);
    note_res_t r;
    int key, slot;
    logic [TB-1:0] start;
    logic [6:0] sv;
    r = '0;
    key = {ch, p};
    if (op == OP_END) begin
      if (failed) r.status = ST_IGNORED;
      else if (sounding != 0) begin
        r.status = ST_END_SOUND;
        r.len = TB'(sounding);
      end else if (finished == 0) r.status = ST_END_EMPTY;
      else begin
        r.status = ST_END_OK;
        r.start = earliest;
        r.len = latest - earliest;
      end
      clear_track();
    end else if (op == OP_BAD || failed) begin
      r.status = ST_IGNORED;
    end else if (op == OP_ON) begin
      if (sounding >= max_snd || sounding >= SLOTS) begin
        failed = 1;
        r.status = ST_SND_LIMIT;
      end else begin
        slot = free_list[(SLOTS - 1 - sounding) % SLOTS];
        s_tick[slot] = tick;
        s_vel[slot] = v;
        s_next[slot] = 0;
        if (hv[key]) s_next[tail[key]] = slot;
        else begin
          hv[key] = 1;
          head[key] = slot;
        end
        tail[key] = slot;
        sounding++;
        r.status = ST_QUEUED;
      end
    end else begin
      if (!hv[key]) begin
        failed = 1;
        r.status = ST_UNMATCHED;
      end else begin
        slot = head[key];
        start = s_tick[slot];
        sv = s_vel[slot];
        if (tail[key] == slot) hv[key] = 0;
        else head[key] = s_next[slot];
        sounding--;
        free_list[(SLOTS - 1 - sounding) % SLOTS] = slot;
        if (tick <= start) begin
          failed = 1;
          r.status = ST_NONPOS;
        end else if (finished >= max_fin) begin
          failed = 1;
          r.status = ST_NOTE_LIM;
        end else begin
          finished = (finished + 1) & 20'hfffff;
          if (start < earliest) earliest = start;
          if (tick > latest) latest = tick;
          r.status = ST_DONE;
          r.start = start;
          r.len = tick - start;
          r.svel = 16'((int'(sv) * 65535 + 63) / 127);
          r.pitch = p;
          r.chan = ch;
        end
      end
    end
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // one transaction on the request channel; valid stays up between back-to-back items unless a random gap is drawn
  task automatic send_note(op_e op, logic [TB-1:0] tick, logic [3:0] ch, logic [6:0] p,
                           logic [6:0] v, bit typed = 0, note_res_t tres = '0);
    note_res_t r;
    r = match_note(op, tick, ch, p, v);
    if (typed) r = tres;
    due_q = {due_q, r};
    if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_pct) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.tick <= tick;
    req_if.channel <= ch;
    req_if.pitch <= p;
    req_if.velocity <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
    // covers the clearing sweep that follows an end of track
    repeat (2100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgBits'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_SND) max_snd = value & 9'h1ff;
    else max_fin = value & 20'hfffff;
  endtask

  task automatic add_row(op_e op, logic [TB-1:0] tick, logic [3:0] ch, logic [6:0] p,
                         logic [6:0] v, bit typed = 0, note_res_t tres = '0);
    stim_row_t s;
    s = '{op, tick, ch, p, v, typed, tres};
    table_q = {table_q, s};
  endtask

  function automatic note_res_t res_of(status_e st, logic [TB-1:0] start = '0,
                                       logic [TB-1:0] len = '0, logic [15:0] sv = '0,
                                       logic [6:0] p = '0, logic [3:0] ch = '0);
    note_res_t r;
    r = '{st, start, len, sv, p, ch};
    return r;
  endfunction

  // random track content: mostly matched on/off pairs over a few keys, some noise
  task automatic play_tracks(int n, int key_pool);
    int keys[6];
    logic [TB-1:0] base;
    int r, idx, k;
    for (int i = 0; i < 6; i++) keys[i] = $urandom_range(KeyCount - 1);
    base = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3 || i == n - 1) begin
        send_note(OP_END, {16'($urandom), 32'($urandom)}, 4'($urandom), 7'($urandom),
                  7'($urandom));
        open_keys.delete();
        base = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 3);
      end else if (r < 6) begin
        send_note(op_e'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)},
                  4'($urandom), 7'($urandom), 7'($urandom));
      end else if (open_keys.size() > 0 && r < 50) begin
        idx = $urandom_range(open_keys.size() - 1);
        k = open_keys[idx];
        open_keys.delete(idx);
        base = base + 1 + $urandom_range(0, 40);
        send_note(OP_OFF, base, 4'(k >> 7), 7'(k), 7'($urandom));
      end else begin
        k = ($urandom_range(9) < 8) ? keys[$urandom_range(key_pool - 1)]
                                    : $urandom_range(KeyCount - 1);
        base = base + $urandom_range(0, 3);
        open_keys = {open_keys, k};
        send_note(OP_ON, base, 4'(k >> 7), 7'(k), 7'($urandom));
      end
    end
  endtask

  // receiver: random stall, or a long hold-off when asked
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= !(rx_pct > 0 && $urandom_range(99) < rx_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      note_res_t exp_r;
      bit bad;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result, status %0d", rsp_if.status);
      end else begin
        exp_r = due_q[0];
        due_q.delete(0);
        status_seen[exp_r.status]++;
        bad = (rsp_if.status != exp_r.status) || (rsp_if.start_tick != exp_r.start) ||
              (rsp_if.length_ticks != exp_r.len) || (rsp_if.scaled_velocity != exp_r.svel) ||
              (rsp_if.note_pitch != exp_r.pitch) || (rsp_if.note_channel != exp_r.chan);
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp st %0d start %0h len %0h vel %0h p %0d ch %0d",
                     exp_r.status, exp_r.start, exp_r.len, exp_r.svel, exp_r.pitch,
                     exp_r.chan);
            $display("          got st %0d start %0h len %0h vel %0h p %0d ch %0d",
                     rsp_if.status, rsp_if.start_tick, rsp_if.length_ticks,
                     rsp_if.scaled_velocity, rsp_if.note_pitch, rsp_if.note_channel);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.operation = '0;
    req_if.tick = '0;
    req_if.channel = '0;
    req_if.pitch = '0;
    req_if.velocity = '0;
    tx_pct = 0;
    rx_pct = 0;
    hold_left = 0;
    clear_track();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(OP_END, 0, 0, 0, 0, 1, res_of(ST_END_EMPTY));
    add_row(OP_OFF, 5, 0, 0, 0, 1, res_of(ST_UNMATCHED));
    add_row(OP_ON, 6, 0, 0, 9, 1, res_of(ST_IGNORED));
    add_row(OP_END, 7, 0, 0, 0, 1, res_of(ST_IGNORED));
    add_row(OP_ON, 0, 15, 127, 127, 1, res_of(ST_QUEUED));
    add_row(OP_ON, TMAX, 0, 0, 0, 1, res_of(ST_QUEUED));
    add_row(OP_OFF, TMAX, 15, 127, 0, 1, res_of(ST_DONE, 0, TMAX, 16'hffff, 127, 15));
    add_row(OP_ON, 5, 15, 127, 1);
    add_row(OP_ON, 6, 15, 127, 64);
    add_row(OP_OFF, 10, 15, 127, 0);
    add_row(OP_OFF, 10, 15, 127, 0);
    add_row(OP_END, 11, 0, 0, 0, 1, res_of(ST_END_SOUND, 0, 1));
    add_row(OP_BAD, 3, 1, 2, 3, 1, res_of(ST_IGNORED));
    add_row(OP_ON, 100, 3, 60, 42);
    add_row(OP_OFF, 100, 3, 60, 0, 1, res_of(ST_NONPOS));
    add_row(OP_END, 101, 0, 0, 0, 1, res_of(ST_IGNORED));
    add_row(OP_ON, 10, 1, 1, 100);
    add_row(OP_OFF, 30, 1, 1, 0);
    add_row(OP_END, 31, 0, 0, 0, 1, res_of(ST_END_OK, 10, 20));
    foreach (table_q[i])
      send_note(table_q[i].op, table_q[i].tick, table_q[i].chan, table_q[i].pitch,
                table_q[i].vel, table_q[i].typed, table_q[i].res);
    drain();

    // limits: refused note-on, then note limit after a matched pair
    write_reg(CFG_MAX_SND, 0);
    write_reg(CFG_MAX_FIN, 0);
    send_note(OP_ON, 1, 2, 3, 4, 1, res_of(ST_SND_LIMIT));
    send_note(OP_END, 2, 0, 0, 0, 1, res_of(ST_IGNORED));
    drain();
    write_reg(CFG_MAX_SND, 256);
    send_note(OP_ON, 1, 2, 3, 4);
    send_note(OP_OFF, 9, 2, 3, 0, 1, res_of(ST_NOTE_LIM));
    send_note(OP_END, 10, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 65; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 65; end
        default: begin tx_pct = 7; rx_pct = 7; end
      endcase
      case (ph)
        0: begin write_reg(CFG_MAX_SND, 256); write_reg(CFG_MAX_FIN, 1048575); end
        1: begin write_reg(CFG_MAX_SND, 4);   write_reg(CFG_MAX_FIN, 1048575); end
        2: begin write_reg(CFG_MAX_SND, 1);   write_reg(CFG_MAX_FIN, 3);       end
        3: begin write_reg(CFG_MAX_SND, 0);   write_reg(CFG_MAX_FIN, 10);      end
        4: begin write_reg(CFG_MAX_SND, 256); write_reg(CFG_MAX_FIN, 0);       end
        5: begin
          write_reg(CFG_MAX_SND, $urandom_range(2, 40));
          write_reg(CFG_MAX_FIN, $urandom_range(1, 30));
        end
        default: begin write_reg(CFG_MAX_SND, 256); write_reg(CFG_MAX_FIN, 1048575); end
      endcase
      // long receiver hold-off while items keep coming
      if (ph == 0 || ph == 6) hold_left = 300;
      play_tracks(95, (ph % 2) ? 2 : 6);
      drain();
    end

    tx_pct = 0;
    rx_pct = 0;
    repeat (20) @(posedge clk_i);
    $display("covered %0d items, %0d results, all operations, both limits and error paths",
             sent, checked);
    $display("status counts: done %0d, end ok %0d, still sounding %0d, ignored %0d",
             status_seen[ST_DONE], status_seen[ST_END_OK], status_seen[ST_END_SOUND],
             status_seen[ST_IGNORED]);
    if (errors == 0 && due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results missing", errors, due_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== midi_note_pair_matcher_top.f =====
+incdir+design
design/mnpm_pkg.sv
design/mnpm_if.sv
design/mnpm_ctrl.sv
design/mnpm_dpath.sv
design/midi_note_pair_matcher_top.sv
tb/tb_midi_note_pair_matcher_top.sv
